### hw/rtl/resource_file_stream_parser_defines.svh
// Assertion macros shared by the parser's checker.
// Pulled in by rfsp_checker.sv; no other dependencies.
`ifndef RESOURCE_FILE_STREAM_PARSER_DEFINES_SVH
`define RESOURCE_FILE_STREAM_PARSER_DEFINES_SVH

// Check a property on every clock edge outside of reset.
`define RFSP_ASSERT(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RFSP_ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

### hw/rtl/rfsp_pkg.sv
// Types and constants for the resource file stream parser.
// Used by resource_file_stream_parser and rfsp_checker; no dependencies.
package rfsp_pkg;

  // Parser phases
  typedef enum logic [2:0] {
    PH_MAGIC,
    PH_VERSION,
    PH_COUNT,
    PH_RESNUM,
    PH_LANG,
    PH_STRING,
    PH_DONE
  } phase_t;

  // File status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MAGIC    = 3'd1;
  localparam logic [2:0] ST_VERSION  = 3'd2;
  localparam logic [2:0] ST_NEGATIVE = 3'd3;
  localparam logic [2:0] ST_TOOLONG  = 3'd4;
  localparam logic [2:0] ST_TRUNC    = 3'd5;

  // Result kinds
  localparam logic KIND_CHAR   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Configuration register indexes
  localparam logic REG_EXPECTED_VERSION = 1'b0;
  localparam logic REG_STRING_LIMIT     = 1'b1;

  // Configuration reset values
  localparam logic [31:0] EXPECTED_VERSION_RESET = 32'd5;
  localparam logic [15:0] STRING_LIMIT_RESET     = 16'd20000;

  // Header magic, byte by byte
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = 8'h52;
      2'd1:    val = 8'h53;
      2'd2:    val = 8'h43;
      default: val = 8'h01;
    endcase
    return val;
  endfunction

endpackage

### hw/rtl/resource_file_stream_parser.sv
// Resource file stream parser: byte-wide header/record decoder with string output.
// Depends on rfsp_pkg.
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   input    | in_valid/in_ready, data_byte, end_of_stream | in
//   result   | out_valid/out_ready, kind, char_byte,      | out
//            | resource_number, language_id, last, status |
//   config   | cfg_write, cfg_index, cfg_data             | in
//
// One byte per cycle while in_ready is high; a result is registered and appears in the cycle after its transaction.
// The parse decision for a byte is a single pass of logic between the parser
// state and the result register, so throughput is set by that register alone.
// in_ready stays high while the result register is empty or being drained.
// Synchronous reset clears parser state and loads the register defaults.
module resource_file_stream_parser (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_stream,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [7:0]  char_byte,
  output logic [31:0] resource_number,
  output logic [31:0] language_id,
  output logic        last,
  output logic [2:0]  status,
  // configuration
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration registers
  logic [31:0] expected_version;
  logic [15:0] string_limit;

  // parser state
  rfsp_pkg::phase_t phase, phase_next;
  logic [1:0]  byte_index, byte_index_next;
  logic [31:0] word_shift, word_shift_next;
  logic [30:0] remaining_count, remaining_count_next;
  logic [31:0] current_resource, current_resource_next;
  logic [31:0] current_language, current_language_next;
  logic [15:0] string_position, string_position_next;
  logic [2:0]  error_code, error_code_next;

  // result produced by this transaction
  logic        emit;
  logic        emit_kind;
  logic [7:0]  emit_char;
  logic [31:0] emit_resource;
  logic [31:0] emit_language;
  logic        emit_last;
  logic [2:0]  emit_status;

  logic        in_fire;
  logic [31:0] word_new;
  logic [15:0] limit_pos;

  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign word_new  = {data_byte, word_shift[31:8]};
  assign limit_pos = string_limit - 16'd1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= rfsp_pkg::EXPECTED_VERSION_RESET;
      string_limit     <= rfsp_pkg::STRING_LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        rfsp_pkg::REG_EXPECTED_VERSION: expected_version <= cfg_data;
        rfsp_pkg::REG_STRING_LIMIT:     string_limit     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Decode one byte: next parser state and optional result
  always_comb begin
    phase_next            = phase;
    byte_index_next       = byte_index;
    word_shift_next       = word_shift;
    remaining_count_next  = remaining_count;
    current_resource_next = current_resource;
    current_language_next = current_language;
    string_position_next  = string_position;
    error_code_next       = error_code;
    emit          = 1'b0;
    emit_kind     = rfsp_pkg::KIND_CHAR;
    emit_char     = 8'd0;
    emit_resource = 32'd0;
    emit_language = 32'd0;
    emit_last     = 1'b0;
    emit_status   = rfsp_pkg::ST_OK;

    if (end_of_stream) begin
      // report the decision (or truncation) and restart
      emit        = 1'b1;
      emit_kind   = rfsp_pkg::KIND_STATUS;
      emit_status = (phase == rfsp_pkg::PH_DONE) ? error_code : rfsp_pkg::ST_TRUNC;
      phase_next            = rfsp_pkg::PH_MAGIC;
      byte_index_next       = 2'd0;
      word_shift_next       = 32'd0;
      remaining_count_next  = 31'd0;
      current_resource_next = 32'd0;
      current_language_next = 32'd0;
      string_position_next  = 16'd0;
      error_code_next       = rfsp_pkg::ST_OK;
    end else begin
      case (phase)
        rfsp_pkg::PH_DONE: ;

        rfsp_pkg::PH_MAGIC: begin
          if (data_byte != rfsp_pkg::magic_byte(byte_index)) begin
            error_code_next = rfsp_pkg::ST_MAGIC;
            phase_next      = rfsp_pkg::PH_DONE;
          end else begin
            byte_index_next = byte_index + 2'd1;
            if (byte_index == 2'd3) begin
              phase_next = rfsp_pkg::PH_VERSION;
            end
          end
        end

        rfsp_pkg::PH_STRING: begin
          if (string_position == limit_pos) begin
            error_code_next = rfsp_pkg::ST_TOOLONG;
            phase_next      = rfsp_pkg::PH_DONE;
          end else begin
            emit          = 1'b1;
            emit_char     = data_byte;
            emit_resource = current_resource;
            emit_language = current_language;
            emit_last     = (data_byte == 8'd0);
            if (data_byte == 8'd0) begin
              // terminator: close the record
              string_position_next = 16'd0;
              remaining_count_next = remaining_count - 31'd1;
              if (remaining_count == 31'd1) begin
                error_code_next = rfsp_pkg::ST_OK;
                phase_next      = rfsp_pkg::PH_DONE;
              end else begin
                phase_next = rfsp_pkg::PH_RESNUM;
              end
            end else begin
              string_position_next = string_position + 16'd1;
            end
          end
        end

        default: begin
          // assemble a little-endian word
          word_shift_next = word_new;
          byte_index_next = byte_index + 2'd1;
          if (byte_index == 2'd3) begin
            case (phase)
              rfsp_pkg::PH_VERSION: begin
                if (word_new != expected_version) begin
                  error_code_next = rfsp_pkg::ST_VERSION;
                  phase_next      = rfsp_pkg::PH_DONE;
                end else begin
                  phase_next = rfsp_pkg::PH_COUNT;
                end
              end
              rfsp_pkg::PH_COUNT: begin
                if (word_new[31]) begin
                  error_code_next = rfsp_pkg::ST_NEGATIVE;
                  phase_next      = rfsp_pkg::PH_DONE;
                end else begin
                  remaining_count_next = word_new[30:0];
                  if (word_new[30:0] == 31'd0) begin
                    error_code_next = rfsp_pkg::ST_OK;
                    phase_next      = rfsp_pkg::PH_DONE;
                  end else begin
                    phase_next = rfsp_pkg::PH_RESNUM;
                  end
                end
              end
              rfsp_pkg::PH_RESNUM: begin
                current_resource_next = word_new;
                phase_next            = rfsp_pkg::PH_LANG;
              end
              default: begin
                current_language_next = word_new;
                string_position_next  = 16'd0;
                phase_next            = rfsp_pkg::PH_STRING;
              end
            endcase
          end
        end
      endcase
    end
  end

  // Advance parser state on each input transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= rfsp_pkg::PH_MAGIC;
      byte_index       <= 2'd0;
      word_shift       <= 32'd0;
      remaining_count  <= 31'd0;
      current_resource <= 32'd0;
      current_language <= 32'd0;
      string_position  <= 16'd0;
      error_code       <= rfsp_pkg::ST_OK;
    end else if (in_fire) begin
      phase            <= phase_next;
      byte_index       <= byte_index_next;
      word_shift       <= word_shift_next;
      remaining_count  <= remaining_count_next;
      current_resource <= current_resource_next;
      current_language <= current_language_next;
      string_position  <= string_position_next;
      error_code       <= error_code_next;
    end
  end

  // Hold the result register until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      kind            <= emit_kind;
      char_byte       <= emit_char;
      resource_number <= emit_resource;
      language_id     <= emit_language;
      last            <= emit_last;
      status          <= emit_status;
    end
  end

endmodule

### hw/rtl/rfsp_checker.sv
// Port-level checks for resource_file_stream_parser, attached by bind.
// Depends on rfsp_pkg and resource_file_stream_parser_defines.svh.
`include "resource_file_stream_parser_defines.svh"

module rfsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        end_of_stream,
  input logic        out_valid,
  input logic        out_ready,
  input logic        kind,
  input logic [7:0]  char_byte,
  input logic [31:0] resource_number,
  input logic [31:0] language_id,
  input logic        last,
  input logic [2:0]  status
);

  // A stalled result stays valid and keeps its status and kind
  `RFSP_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(kind), "result changed while stalled")

  // An end-of-stream transaction yields a status result next cycle
  `RFSP_ASSERT(a_eos_status, clk, rst, in_valid && in_ready && end_of_stream |=> out_valid && kind == rfsp_pkg::KIND_STATUS, "end of stream gave no status")

  // A string byte carries no status, and last marks exactly the terminator
  `RFSP_ASSERT(a_char_fields, clk, rst, out_valid && kind == rfsp_pkg::KIND_CHAR |-> status == rfsp_pkg::ST_OK && last == (char_byte == 8'd0), "bad string byte result")

  // A status result has zero record fields and a known code
  `RFSP_ASSERT(a_status_fields, clk, rst, out_valid && kind == rfsp_pkg::KIND_STATUS |-> char_byte == 8'd0 && resource_number == 32'd0 && language_id == 32'd0 && !last && status <= rfsp_pkg::ST_TRUNC, "bad status result")

  // Reset empties the result register
  `RFSP_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result valid after reset")

endmodule

bind resource_file_stream_parser rfsp_checker u_rfsp_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .end_of_stream   (end_of_stream),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .kind            (kind),
  .char_byte       (char_byte),
  .resource_number (resource_number),
  .language_id     (language_id),
  .last            (last),
  .status          (status)
);
